// ===== sv/olde_pkg.sv =====
// Shared types, request and status codes for the ordered list deque engine.
package olde_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   // request codes
   localparam logic [2:0] REQ_INSERT_ORDERED = 3'd0;
   localparam logic [2:0] REQ_DELETE_VALUE   = 3'd1;
   localparam logic [2:0] REQ_PUSH_FRONT     = 3'd2;
   localparam logic [2:0] REQ_PUSH_BACK      = 3'd3;
   localparam logic [2:0] REQ_POP_FRONT      = 3'd4;
   localparam logic [2:0] REQ_POP_BACK       = 3'd5;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]        req_type;
      logic signed [7:0] item_value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]        status;
      logic signed [7:0] removed_value;
      logic [4:0]        entry_count;
   } rsp_payload_type;

   // broadcast to every cell
   typedef struct packed {
      logic [2:0]        req_type;
      logic signed [7:0] item_value;
      logic              do_insert;
      logic              do_remove;
   } cell_cmd_type;

   // rippled from cell to cell, front to back
   typedef struct packed {
      logic              found;
      logic signed [7:0] removed;
   } cell_chain_type;

endpackage

// ===== sv/olde_cell.sv =====
// One storage cell of the ordered list: holds one entry and shifts with its neighbors.
module olde_cell
   import olde_pkg::*;
(
   input  logic              clock,
   input  cell_cmd_type      cmd,
   input  logic              valid_here,
   input  logic              valid_next,
   input  logic signed [7:0] left_value,
   input  logic signed [7:0] right_value,
   input  cell_chain_type    chain_in,
   output cell_chain_type    chain_out,
   output logic signed [7:0] entry_value
);

   logic signed [7:0] entry_ff;
   logic signed [7:0] entry_in;
   logic              stop;
   logic              hit;

   // is this the cell where the request takes effect
   always_comb begin
      unique case (cmd.req_type) inside
         REQ_INSERT_ORDERED: stop = !valid_here || !(cmd.item_value > entry_ff);
         REQ_DELETE_VALUE:   stop = valid_here && (entry_ff == cmd.item_value);
         REQ_PUSH_FRONT, REQ_POP_FRONT: stop = 1'b1;
         REQ_PUSH_BACK:      stop = !valid_here;
         REQ_POP_BACK:       stop = valid_here && !valid_next;
         default:            stop = 1'b0;
      endcase
   end

   assign hit               = stop && !chain_in.found;
   assign chain_out.found   = chain_in.found || stop;
   assign chain_out.removed = hit ? entry_ff : chain_in.removed;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.do_insert) begin
         if (chain_in.found) begin
            entry_in = left_value;
         end else if (stop) begin
            entry_in = cmd.item_value;
         end
      end else if (cmd.do_remove && (chain_in.found || stop)) begin
         entry_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;

endmodule

// ===== sv/ordered_list_deque_engine.sv =====
// Top level of the ordered list deque engine: a row of shifting cells plus count and response.
// The result strobe rises in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle; busy is high only during reset, so start may stay high.
// Each cycle's work is one ripple through the cell row (find position, then shift).
// Reset (synchronous, active high) empties the list and drops any pending result.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ordered_list_deque_engine
   import olde_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_data,
   output logic            rsp_strobe,
   output rsp_payload_type rsp_data
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = (CNT_W > 5) ? CNT_W : 5;

   logic [CNT_W-1:0]  occupancy_ff;
   logic [CNT_W-1:0]  occupancy_in;
   logic              rsp_strobe_ff;
   rsp_payload_type   rsp_ff;
   rsp_payload_type   rsp_in;

   logic              accept;
   logic              is_insert;
   logic              is_remove;
   logic              full;
   logic              empty;
   logic              found;
   cell_cmd_type      cmd;

   logic [CAPACITY-1:0]    valid;
   logic signed [7:0]      cell_value [CAPACITY];
   cell_chain_type         chain      [CAPACITY+1];
   logic [WIDE_W-1:0]      count_wide;

   // the block keeps pace with the request stream; refuse transactions only in reset
   assign busy   = reset;
   assign accept = start && !busy;

   assign full  = (occupancy_ff == CNT_W'(CAPACITY));
   assign empty = (occupancy_ff == '0);

   always_comb begin
      is_insert = 1'b0;
      is_remove = 1'b0;
      unique case (req_data.req_type) inside
         REQ_INSERT_ORDERED, REQ_PUSH_FRONT, REQ_PUSH_BACK: is_insert = 1'b1;
         REQ_DELETE_VALUE, REQ_POP_FRONT, REQ_POP_BACK:     is_remove = 1'b1;
         default: ;
      endcase
   end

   // broadcast the request; gate shifting on room and content
   always_comb begin
      cmd.req_type   = req_data.req_type;
      cmd.item_value = req_data.item_value;
      cmd.do_insert  = accept && is_insert && !full;
      cmd.do_remove  = accept && is_remove && !empty;
   end

   assign chain[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [7:0] left_v;
      logic signed [7:0] right_v;
      logic              valid_nxt;

      assign valid[i] = (occupancy_ff > CNT_W'(i));

      if (i == 0) begin : g_first
         assign left_v = req_data.item_value;
      end else begin : g_mid_left
         assign left_v = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_v   = cell_value[i];
         assign valid_nxt = 1'b0;
      end else begin : g_mid_right
         assign right_v   = cell_value[i+1];
         assign valid_nxt = (occupancy_ff > CNT_W'(i + 1));
      end

      olde_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .valid_here  (valid[i]),
         .valid_next  (valid_nxt),
         .left_value  (left_v),
         .right_value (right_v),
         .chain_in    (chain[i]),
         .chain_out   (chain[i+1]),
         .entry_value (cell_value[i])
      );
   end

   assign found = chain[CAPACITY].found;

   // count update and status
   always_comb begin
      occupancy_in         = occupancy_ff;
      rsp_in.status        = STATUS_OK;
      rsp_in.removed_value = '0;
      if (is_insert) begin
         if (full) begin
            rsp_in.status = STATUS_FULL;
         end else begin
            occupancy_in = occupancy_ff + CNT_W'(1);
         end
      end else if (is_remove) begin
         if (empty) begin
            rsp_in.status = STATUS_EMPTY;
         end else if (!found) begin
            rsp_in.status = STATUS_NOT_FOUND;
         end else begin
            occupancy_in         = occupancy_ff - CNT_W'(1);
            rsp_in.removed_value = chain[CAPACITY].removed;
         end
      end
      count_wide         = WIDE_W'(occupancy_in);
      rsp_in.entry_count = count_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            occupancy_ff <= occupancy_in;
         end
      end
   end

   // hold the result payload; strobe marks the one valid cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== verif/tb_ordered_list_deque_engine.sv =====
// Self-checking testbench for the ordered list deque engine: directed and random request traffic.
module tb_ordered_list_deque_engine;
   import olde_pkg::*;

   localparam int CAPACITY    = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT = 40000;
   localparam int DRAIN_WAIT  = 4;
   localparam int GAP_PCT     = 22;
   // the two request codes the engine does not define
   localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
   localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req_data = '0;
   logic            rsp_strobe;
   rsp_payload_type rsp_data;

   // shadow copy of the list contents, front at index 0
   logic signed [7:0] list_vals [CAPACITY];
   int                list_count = 0;

   req_payload_type pending_reqs [$];
   rsp_payload_type expected_rsps [$];
   int              accepted_count = 0;
   int              fail_count = 0;
   int              cycle_count = 0;

   ordered_list_deque_engine #(.CAPACITY(CAPACITY)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Open a slot at pos and write the value; entries behind it shift back.
   function automatic void open_slot(int pos, logic signed [7:0] val);
      for (int i = list_count; i > pos; i--) list_vals[i] = list_vals[i - 1];
      list_vals[pos] = val;
      list_count++;
   endfunction

   // Close the slot at pos and return what it held; entries behind it shift forward.
   function automatic logic signed [7:0] close_slot(int pos);
      logic signed [7:0] val;
      val = list_vals[pos];
      for (int i = pos; i + 1 < list_count; i++) list_vals[i] = list_vals[i + 1];
      list_count--;
      return val;
   endfunction

   // Apply one request to the shadow list and return the response it must produce.
   function automatic rsp_payload_type apply_request(req_payload_type rq);
      rsp_payload_type r;
      int              pos;
      r.status        = STATUS_OK;
      r.removed_value = '0;
      case (rq.req_type)
         REQ_INSERT_ORDERED: begin
            if (list_count >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               // land after every smaller entry, ahead of equal ones
               pos = 0;
               while (pos < list_count && rq.item_value > list_vals[pos]) pos++;
               open_slot(pos, rq.item_value);
            end
         end
         REQ_DELETE_VALUE: begin
            if (list_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               pos = 0;
               while (pos < list_count && list_vals[pos] != rq.item_value) pos++;
               if (pos < list_count) r.removed_value = close_slot(pos);
               else r.status = STATUS_NOT_FOUND;
            end
         end
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (list_count >= CAPACITY) r.status = STATUS_FULL;
            else open_slot(rq.req_type == REQ_PUSH_FRONT ? 0 : list_count, rq.item_value);
         end
         REQ_POP_FRONT, REQ_POP_BACK: begin
            if (list_count == 0) r.status = STATUS_EMPTY;
            else r.removed_value = close_slot(rq.req_type == REQ_POP_FRONT ? 0 : list_count - 1);
         end
         default: begin
            // unused codes leave the list alone
         end
      endcase
      r.entry_count = 5'(list_count);
      return r;
   endfunction

   function automatic void queue_request(logic [2:0] kind, logic signed [7:0] val);
      req_payload_type rq;
      rq.req_type   = kind;
      rq.item_value = val;
      pending_reqs.push_back(rq);
   endfunction

   // Draw a value: sometimes an extreme, else a narrow band (to make deletes hit) or the full range.
   function automatic logic signed [7:0] pick_value(bit narrow);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         case ($urandom_range(0, 3))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 8'sd0;
            default: return -8'sd1;
         endcase
      end
      if (narrow) return 8'($urandom_range(0, 8) - 4);
      return 8'($urandom_range(0, 255));
   endfunction

   // Build the stimulus: a directed opening, then random phases that swing
   // the list between full and empty.
   initial begin
      int         grow_pct;
      bit         narrow;
      logic [2:0] kind;

      // empty list: pops and delete answer empty; unused codes pass through
      queue_request(REQ_POP_FRONT, 8'sd5);
      queue_request(REQ_POP_BACK, -8'sd5);
      queue_request(REQ_DELETE_VALUE, 8'sd0);
      queue_request(REQ_UNUSED_6, 8'sd127);
      queue_request(REQ_UNUSED_7, -8'sd128);
      // ordered inserts at the extremes, plus a duplicate
      queue_request(REQ_INSERT_ORDERED, -8'sd128);
      queue_request(REQ_INSERT_ORDERED, 8'sd127);
      queue_request(REQ_INSERT_ORDERED, 8'sd0);
      queue_request(REQ_INSERT_ORDERED, 8'sd0);
      // absent value, then a hit
      queue_request(REQ_DELETE_VALUE, 8'sd55);
      queue_request(REQ_DELETE_VALUE, 8'sd0);
      queue_request(REQ_PUSH_FRONT, 8'sd127);
      queue_request(REQ_PUSH_BACK, -8'sd128);
      queue_request(REQ_POP_FRONT, 8'sd0);
      queue_request(REQ_POP_BACK, 8'sd0);
      // overfill: the last few pushes are refused as full
      for (int i = 0; i < CAPACITY; i++) begin
         queue_request(i % 2 ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value(1'b0));
      end
      queue_request(REQ_INSERT_ORDERED, 8'sd1);

      for (int phase = 0; phase < 26; phase++) begin
         case (phase % 4)
            0:       grow_pct = 80;
            1:       grow_pct = 20;
            2:       grow_pct = 55;
            default: grow_pct = 45;
         endcase
         narrow = $urandom_range(0, 1);
         for (int k = 0; k < 50; k++) begin
            if ($urandom_range(0, 99) < 3) begin
               kind = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
            end else if ($urandom_range(0, 99) < grow_pct) begin
               case ($urandom_range(0, 3))
                  0:       kind = REQ_PUSH_FRONT;
                  1:       kind = REQ_PUSH_BACK;
                  default: kind = REQ_INSERT_ORDERED;
               endcase
            end else begin
               case ($urandom_range(0, 3))
                  0:       kind = REQ_POP_FRONT;
                  1:       kind = REQ_POP_BACK;
                  default: kind = REQ_DELETE_VALUE;
               endcase
            end
            queue_request(kind, pick_value(narrow));
         end
      end
   end

   // Driver: on each accepted transaction, predict its response and advance
   // to the next pending request; otherwise insert a random idle cycle.
   always @(posedge clock) begin
      logic            next_start;
      logic            gap;
      req_payload_type next_req;
      next_start = 1'b0;
      next_req   = req_data;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(apply_request(req_data));
            void'(pending_reqs.pop_front());
            accepted_count++;
         end
         if (start && busy) begin
            // hold the request until the engine takes it
            next_start = 1'b1;
         end else if (pending_reqs.size() > 0) begin
            // keep a long stretch of back-to-back transactions with no idling
            gap = (accepted_count < 500 || accepted_count >= 800) &&
                  ($urandom_range(0, 99) < GAP_PCT);
            if (!gap) begin
               next_start = 1'b1;
               next_req   = pending_reqs[0];
            end
         end
         start    <= next_start;
         req_data <= next_req;
      end
   end

   // Monitor: each strobed response must match the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: status %0d removed_value %0d entry_count %0d",
                   rsp_data.status, rsp_data.removed_value, rsp_data.entry_count);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.removed_value !== want.removed_value) begin
               $error("removed_value: expected %0d, actual %0d",
                      want.removed_value, rsp_data.removed_value);
               fail_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d",
                      want.entry_count, rsp_data.entry_count);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Release reset, wait for all traffic to drain, then report.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_reqs.size() > 0 || start) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      // give a stray response time to show up
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
